// ----- src/ses_pkg.sv -----
// Package: widths, item codes and shared types for the segment end shortener.
package ses_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int LEN_WIDTH   = 31;
    localparam int MODE_WIDTH  = 2;
    localparam int SPAN_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = LEN_WIDTH + SPAN_WIDTH;
    localparam int EXT_WIDTH   = COORD_WIDTH + 3;
    localparam int DIV_STAGES  = LEN_WIDTH;
    localparam int IN_DATA_W   = ((4 * COORD_WIDTH + LEN_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 4 * COORD_WIDTH;

    localparam logic [MODE_WIDTH-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_START = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_END   = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_BOTH  = 2'd3;

    localparam logic [2:0] CAT_PASS     = 3'd0;
    localparam logic [2:0] CAT_MID      = 3'd1;
    localparam logic [2:0] CAT_TO_END   = 3'd2;
    localparam logic [2:0] CAT_TO_START = 3'd3;
    localparam logic [2:0] CAT_MOVE     = 3'd4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x1;
        logic signed [COORD_WIDTH-1:0] y1;
        logic signed [COORD_WIDTH-1:0] x2;
        logic signed [COORD_WIDTH-1:0] y2;
        logic signed [SPAN_WIDTH-1:0]  run;
        logic signed [SPAN_WIDTH-1:0]  rise;
        logic [LEN_WIDTH-1:0]          len;
        logic [MODE_WIDTH-1:0]         mode;
        logic [2:0]                    cat;
        logic                          x_major;
    } t_side;

    typedef struct packed {
        logic [SPAN_WIDTH-1:0] rem;
        logic [LEN_WIDTH-1:0]  num;
        logic [LEN_WIDTH-1:0]  quo;
        logic [SPAN_WIDTH-1:0] den;
    } t_div;

    function automatic logic signed [COORD_WIDTH-1:0] sat(
        input logic signed [EXT_WIDTH-1:0] v
    );
        logic [EXT_WIDTH-COORD_WIDTH:0] top;
        top = v[EXT_WIDTH-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[EXT_WIDTH-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

// ----- src/ses_front.sv -----
// Front stages: span subtraction, case classification and product.
module ses_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [ses_pkg::IN_DATA_W-1:0]          i_data,
    input  logic [ses_pkg::MODE_WIDTH-1:0]         i_mode,
    output logic                                   o_valid,
    output ses_pkg::t_side                         o_side,
    output ses_pkg::t_div                          o_div
);
    localparam int CW = ses_pkg::COORD_WIDTH;
    localparam int SW = ses_pkg::SPAN_WIDTH;
    localparam int LW = ses_pkg::LEN_WIDTH;
    localparam int PW = ses_pkg::PROD_WIDTH;

    logic           r1_valid, r2_valid, r3_valid;
    ses_pkg::t_side r1_side, r2_side, r3_side;
    ses_pkg::t_side n1_side, n2_side;
    logic [SW-1:0]  r2_minor, r2_major;
    logic [SW-1:0]  n2_minor, n2_major;
    logic [SW-1:0]  dx, dy;
    ses_pkg::t_div  r3_div, n3_div;
    logic [PW-1:0]  prod;

    always_comb begin
        n1_side      = '0;
        n1_side.x1   = i_data[CW-1:0];
        n1_side.y1   = i_data[2*CW-1:CW];
        n1_side.x2   = i_data[3*CW-1:2*CW];
        n1_side.y2   = i_data[4*CW-1:3*CW];
        n1_side.len  = i_data[4*CW+LW-1:4*CW];
        n1_side.mode = i_mode;
        n1_side.run  = SW'(n1_side.x1) - SW'(n1_side.x2);
        n1_side.rise = SW'(n1_side.y1) - SW'(n1_side.y2);
    end

    always_comb begin
        dx      = r1_side.run[SW-1]  ? SW'(-r1_side.run)  : SW'(r1_side.run);
        dy      = r1_side.rise[SW-1] ? SW'(-r1_side.rise) : SW'(r1_side.rise);
        n2_side = r1_side;
        n2_side.x_major = dx > dy;
        n2_major = (dx > dy) ? dx : dy;
        n2_minor = (dx > dy) ? dy : dx;
        priority if (r1_side.mode == ses_pkg::MODE_NONE) begin
            n2_side.cat = ses_pkg::CAT_PASS;
        end else if (r1_side.mode == ses_pkg::MODE_BOTH
                     && {1'b0, r1_side.len, 1'b0} > n2_major) begin
            n2_side.cat = ses_pkg::CAT_MID;
        end else if (r1_side.mode == ses_pkg::MODE_START
                     && {2'b00, r1_side.len} > n2_major) begin
            n2_side.cat = ses_pkg::CAT_TO_END;
        end else if (r1_side.mode == ses_pkg::MODE_END
                     && {2'b00, r1_side.len} > n2_major) begin
            n2_side.cat = ses_pkg::CAT_TO_START;
        end else if (dx == dy) begin
            n2_side.cat = ses_pkg::CAT_PASS;
        end else begin
            n2_side.cat = ses_pkg::CAT_MOVE;
        end
    end

    always_comb begin
        prod       = PW'(r2_side.len) * PW'(r2_minor);
        n3_div.rem = prod[PW-1:LW];
        n3_div.num = prod[LW-1:0];
        n3_div.quo = '0;
        n3_div.den = r2_major;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side  <= n1_side;
            r2_side  <= n2_side;
            r2_major <= n2_major;
            r2_minor <= n2_minor;
            r3_side  <= r2_side;
            r3_div   <= n3_div;
        end
    end

    assign o_valid = r3_valid;
    assign o_side  = r3_side;
    assign o_div   = r3_div;
endmodule

// ----- src/ses_div_stage.sv -----
// One restoring division stage: one quotient bit per stage.
module ses_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  ses_pkg::t_side i_side,
    input  ses_pkg::t_div  i_div,
    output logic           o_valid,
    output ses_pkg::t_side o_side,
    output ses_pkg::t_div  o_div
);
    localparam int SW = ses_pkg::SPAN_WIDTH;
    localparam int LW = ses_pkg::LEN_WIDTH;

    logic           r_valid;
    ses_pkg::t_side r_side;
    ses_pkg::t_div  r_div, n_div;
    logic [SW:0]    shifted, diff;

    always_comb begin
        shifted = {i_div.rem, i_div.num[LW-1]};
        diff    = shifted - {1'b0, i_div.den};
        n_div   = i_div;
        n_div.num = {i_div.num[LW-2:0], 1'b0};
        if (shifted >= {1'b0, i_div.den}) begin
            n_div.rem = diff[SW-1:0];
            n_div.quo = {i_div.quo[LW-2:0], 1'b1};
        end else begin
            n_div.rem = shifted[SW-1:0];
            n_div.quo = {i_div.quo[LW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;
endmodule

// ----- src/ses_back.sv -----
// Back stage: apply moves, collapse cases and saturate into the output register.
module ses_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  ses_pkg::t_side                 i_side,
    input  ses_pkg::t_div                  i_div,
    output logic                           o_valid,
    output logic [ses_pkg::OUT_DATA_W-1:0] o_data
);
    localparam int CW = ses_pkg::COORD_WIDTH;
    localparam int EW = ses_pkg::EXT_WIDTH;

    logic                          r_valid;
    logic [ses_pkg::OUT_DATA_W-1:0] r_data, n_data;
    logic signed [EW-1:0] x1, y1, x2, y2, ax, ay, mx, my, hx, hy;
    logic signed [EW-1:0] x1n, y1n, x2n, y2n;

    always_comb begin
        x1 = EW'(i_side.x1);
        y1 = EW'(i_side.y1);
        x2 = EW'(i_side.x2);
        y2 = EW'(i_side.y2);
        ax = i_side.x_major ? EW'(i_side.len) : EW'(i_div.quo);
        ay = i_side.x_major ? EW'(i_div.quo) : EW'(i_side.len);
        mx = i_side.run[CW]  ? -ax : ax;
        my = i_side.rise[CW] ? -ay : ay;
        hx = (EW'(i_side.run)  + $signed({{(EW-1){1'b0}}, i_side.run[CW]}))  >>> 1;
        hy = (EW'(i_side.rise) + $signed({{(EW-1){1'b0}}, i_side.rise[CW]})) >>> 1;
        x1n = x1;
        y1n = y1;
        x2n = x2;
        y2n = y2;
        unique case (i_side.cat)
            ses_pkg::CAT_MID: begin
                x1n = x1 - hx;
                y1n = y1 - hy;
                x2n = x1 - hx;
                y2n = y1 - hy;
            end
            ses_pkg::CAT_TO_END: begin
                x1n = x2;
                y1n = y2;
            end
            ses_pkg::CAT_TO_START: begin
                x2n = x1;
                y2n = y1;
            end
            ses_pkg::CAT_MOVE: begin
                if (i_side.mode[0]) begin
                    x1n = x1 - mx;
                    y1n = y1 - my;
                end
                if (i_side.mode[1]) begin
                    x2n = x2 + mx;
                    y2n = y2 + my;
                end
            end
            default: begin
                x1n = x1;
            end
        endcase
        n_data = {ses_pkg::sat(y2n), ses_pkg::sat(x2n),
                  ses_pkg::sat(y1n), ses_pkg::sat(x1n)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- src/segment_end_shortener_unit.sv -----
// Top level: segment end shortener pipeline.
// Usage:
//   Slave channel takes one segment per beat: tdata carries start and end
//   points and the trim length, tuser the trim mode. Master channel returns
//   one beat per segment with the adjusted points, in input order.
//   The pipeline has three front stages (span subtraction, case
//   classification, length-by-span product), 31 divider stages that each
//   resolve one quotient bit, and one stage that applies the moves and
//   saturates into the output register.
//   Throughput is one segment per cycle while the receiver does not stall the
//   output; the bit-per-stage divider is what sets the depth.
//   Reset (synchronous, active low) clears all valid bits; payload registers
//   keep whatever they hold.
//   When the receiver drops tready while a result is waiting, the whole
//   pipeline holds in place and o_s_tready falls; nothing is dropped or
//   repeated. Empty stages do not stop the pipeline.
module segment_end_shortener_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // start_x, start_y, end_x, end_y, trim_length, zero pad
    input  logic [ses_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // trim_mode
    input  logic [ses_pkg::MODE_WIDTH-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // new_start_x, new_start_y, new_end_x, new_end_y
    output logic [ses_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    localparam int NS = ses_pkg::DIV_STAGES;

    logic           en;
    logic           v  [NS+1];
    ses_pkg::t_side sd [NS+1];
    ses_pkg::t_div  dv [NS+1];

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    ses_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_mode  (i_s_tuser),
        .o_valid (v[0]),
        .o_side  (sd[0]),
        .o_div   (dv[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        ses_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_side  (sd[g]),
            .i_div   (dv[g]),
            .o_valid (v[g+1]),
            .o_side  (sd[g+1]),
            .o_div   (dv[g+1])
        );
    end

    ses_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[NS]),
        .i_side  (sd[NS]),
        .i_div   (dv[NS]),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );
endmodule

// ----- tb/segment_end_shortener_unit_tb.sv -----
// Testbench for the segment end shortener: directed table plus random bursts, checked by a predictor.
`timescale 1ns / 1ps

module segment_end_shortener_unit_tb;
    import ses_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_SEGMENTS = 550;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        logic [MODE_WIDTH-1:0] mode;
        logic [LEN_WIDTH-1:0] len;
    } segment_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } trimmed_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] i_s_tdata = '0;
    logic [MODE_WIDTH-1:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic o_s_tready;
    logic o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    trimmed_t trimmed_q[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int cycles = 0;
    int mode_seen[4] = '{0, 0, 0, 0};

    segment_end_shortener_unit dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("segment_end_shortener_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic coord_t clamp_coord(longint v);
        longint hi;
        hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        if (v > hi) return coord_t'(hi);
        if (v < -hi - 1) return coord_t'(-hi - 1);
        return coord_t'(v);
    endfunction

    function automatic trimmed_t shorten_segment(segment_t s);
        longint x1, y1, x2, y2, run, rise, dx, dy, major, len, ax, ay, dir;
        logic [95:0] prod;
        trimmed_t r;
        x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
        len = longint'(s.len);
        if (s.mode != MODE_NONE) begin
            run = x1 - x2;
            rise = y1 - y2;
            dx = run < 0 ? -run : run;
            dy = rise < 0 ? -rise : rise;
            major = dx > dy ? dx : dy;
            if (s.mode == MODE_BOTH && 2 * len > major) begin
                x1 = x1 - run / 2;
                y1 = y1 - rise / 2;
                x2 = x1;
                y2 = y1;
            end else if (s.mode == MODE_START && len > major) begin
                x1 = x2;
                y1 = y2;
            end else if (s.mode == MODE_END && len > major) begin
                x2 = x1;
                y2 = y1;
            end else if (x1 == x2) begin
                dir = y1 < y2 ? 1 : -1;
                if (s.mode[0]) y1 += dir * len;
                if (s.mode[1]) y2 -= dir * len;
            end else if (y1 == y2) begin
                dir = x1 < x2 ? 1 : -1;
                if (s.mode[0]) x1 += dir * len;
                if (s.mode[1]) x2 -= dir * len;
            end else if (dx != dy) begin
                if (dy > dx) begin
                    ay = len;
                    prod = 96'(len) * 96'(dx);
                    ax = longint'(prod / 96'(dy));
                end else begin
                    ax = len;
                    prod = 96'(len) * 96'(dy);
                    ay = longint'(prod / 96'(dx));
                end
                if (run < 0) ax = -ax;
                if (rise < 0) ay = -ay;
                if (s.mode[1]) begin
                    x2 += ax;
                    y2 += ay;
                end
                if (s.mode[0]) begin
                    x1 -= ax;
                    y1 -= ay;
                end
            end
        end
        r.x1 = clamp_coord(x1);
        r.y1 = clamp_coord(y1);
        r.x2 = clamp_coord(x2);
        r.y2 = clamp_coord(y2);
        return r;
    endfunction

    task automatic send_segment(segment_t s);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= IN_DATA_W'({s.len, s.y2, s.x2, s.y1, s.x1});
        i_s_tuser <= s.mode;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        trimmed_q.push_back(shorten_segment(s));
        mode_seen[s.mode]++;
        sent++;
    endtask

    task automatic pause_sender(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // receiver: alternate stall-free stretches with random stalls
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_phase < 100) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        trimmed_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            {got.y2, got.x2, got.y1, got.x1} = o_m_tdata;
            received++;
            if (trimmed_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = trimmed_q.pop_front();
                if (got.x1 !== want.x1) begin
                    $display("%0t: new_start_x exp %0d got %0d", $time, want.x1, got.x1);
                    errors++;
                end
                if (got.y1 !== want.y1) begin
                    $display("%0t: new_start_y exp %0d got %0d", $time, want.y1, got.y1);
                    errors++;
                end
                if (got.x2 !== want.x2) begin
                    $display("%0t: new_end_x exp %0d got %0d", $time, want.x2, got.x2);
                    errors++;
                end
                if (got.y2 !== want.y2) begin
                    $display("%0t: new_end_y exp %0d got %0d", $time, want.y2, got.y2);
                    errors++;
                end
            end
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
            default: return coord_t'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        s.x1 = pick_coord();
        s.y1 = pick_coord();
        s.x2 = pick_coord();
        s.y2 = pick_coord();
        case ($urandom_range(0, 7))
            0: s.x2 = s.x1;
            1: s.y2 = s.y1;
            2: begin
                s.x2 = s.x1 + 500;
                s.y2 = s.y1 - 500;
            end
            default: ;
        endcase
        s.mode = MODE_WIDTH'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: s.len = LEN_WIDTH'($urandom);
            1: s.len = LEN_WIDTH'($urandom_range(0, 3000));
            default: s.len = LEN_WIDTH'($urandom_range(0, 600000));
        endcase
        return s;
    endfunction

    segment_t directed_rows[$];
    trimmed_t directed_expected[$];

    task automatic add_row(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                           logic [MODE_WIDTH-1:0] mode, logic [LEN_WIDTH-1:0] len);
        segment_t s;
        s = '{x1, y1, x2, y2, mode, len};
        directed_rows.push_back(s);
    endtask

    initial begin
        segment_t s;
        int burst;
        int drain_wait;
        coord_t cmax, cmin;
        cmax = 32'sh7fffffff;
        cmin = 32'sh80000000;

        add_row(cmin, cmax, cmax, cmin, MODE_NONE, '1);
        add_row(0, 0, 0, 0, MODE_START, 0);
        add_row(0, 0, 0, 0, MODE_BOTH, 0);
        add_row(0, 0, 0, 1000, MODE_BOTH, 100);
        add_row(0, 1000, 0, 0, MODE_END, 100);
        add_row(-50, 7, 950, 7, MODE_START, 300);
        add_row(950, 7, -50, 7, MODE_END, 300);
        add_row(0, 0, 1000, 400, MODE_BOTH, 200);
        add_row(0, 0, -400, 1000, MODE_START, 333);
        add_row(10, 20, -990, -480, MODE_END, 77);
        add_row(0, 0, 500, 500, MODE_BOTH, 100);
        add_row(0, 0, 100, 30, MODE_START, 101);
        add_row(0, 0, 100, 30, MODE_END, 101);
        add_row(1, 1, 100, 30, MODE_BOTH, 50);
        add_row(cmin, cmin, cmax, cmax, MODE_BOTH, '1);
        add_row(cmin, 0, cmax, 0, MODE_START, '1);
        add_row(cmax, 5, cmax, cmin, MODE_END, 1);
        add_row(cmax, cmax, cmax, cmax, MODE_BOTH, 0);
        add_row(cmax, 0, cmax, 0, MODE_START, 0);
        add_row(cmin, 0, cmin, 0, MODE_END, 0);
        add_row(cmin, 3, cmax, -2, MODE_END, '1);
        // zero-length segment with zero trim moves nothing; full-range passthrough is known
        directed_expected.push_back('{cmin, cmax, cmax, cmin});
        directed_expected.push_back('{0, 0, 0, 0});
        directed_expected.push_back('{0, 0, 0, 0});
        directed_expected.push_back('{0, 100, 0, 900});
        directed_expected.push_back('{0, 1000, 0, 100});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (k < directed_expected.size() &&
                shorten_segment(directed_rows[k]) != directed_expected[k]) begin
                $display("%0t: predictor row %0d disagrees with table", $time, k);
                errors++;
            end
            send_segment(directed_rows[k]);
        end

        // hold off until the pipeline has drained completely
        pause_sender(1);
        while (trimmed_q.size() != 0) @(posedge i_clk);

        while (sent < directed_rows.size() + RANDOM_SEGMENTS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                s = random_segment();
                send_segment(s);
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        i_s_tvalid <= 1'b0;

        while (trimmed_q.size() != 0) @(posedge i_clk);
        drain_wait = 0;
        while (drain_wait < 60) begin
            @(posedge i_clk);
            drain_wait++;
        end

        $display("covered %0d segments (none %0d, start %0d, end %0d, both %0d), %0d results",
                 sent, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], received);
        if (errors == 0) begin
            $display("segment_end_shortener_unit_tb: done, clean");
        end else begin
            $display("segment_end_shortener_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ses_pkg.sv
src/ses_front.sv
src/ses_div_stage.sv
src/ses_back.sv
src/segment_end_shortener_unit.sv
tb/segment_end_shortener_unit_tb.sv
